>>> design/physical_page_allocator_assert.svh
// Assertion helpers for the page allocator.
`ifndef PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define PPA_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page allocator assertion failed");

// Next-cycle implication.
`define PPA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page allocator assertion failed");

`endif

>>> design/ppa_pkg.sv
`timescale 1ns / 1ps
package ppa_pkg;

   localparam int unsigned CFG_W      = 13;
   localparam int unsigned MAP_WORD_W = 64;
   localparam int unsigned MAP_BIT_W  = 6;

   localparam logic [CFG_W-1:0] PAGE_TOTAL_RESET = 13'd4096;
   localparam logic [CFG_W-1:0] FIRST_PAGE_RESET = 13'd0;
   localparam logic [CFG_W-1:0] FREE_RESET       = 13'd4096;

   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef enum logic {
      REG_PAGE_TOTAL = 1'b0,
      REG_FIRST_PAGE = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_NO_MEMORY   = 3'd1,
      STATUS_BAD_ADDRESS = 3'd2,
      STATUS_NOT_IN_USE  = 3'd3,
      STATUS_COUNT_ERROR = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_REJECT  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic        func;
      logic [31:0] page_address;
   } req_type;

   typedef struct packed {
      logic [31:0]      granted_address;
      logic [2:0]       status;
      logic [CFG_W-1:0] pages_free;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] page_total;
      logic [CFG_W-1:0] first_page;
      logic             reload;
   } cfg_type;

   function automatic logic [CFG_W-1:0] search_limit(input logic [CFG_W-1:0] total,
                                                     input int unsigned max_pages);
      logic [31:0] total_ext;
      total_ext = 32'(total);
      if (total_ext < max_pages) begin
         return total;
      end else begin
         return CFG_W'(max_pages);
      end
   endfunction

endpackage

>>> design/ppa_queue.sv
`timescale 1ns / 1ps
module ppa_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign data_out = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

>>> design/ppa_front.sv
`timescale 1ns / 1ps
module ppa_front import ppa_pkg::*; #(
   parameter int unsigned MAX_PAGES  = 4096,
   parameter int unsigned PAGE_SHIFT = 12,
   parameter int unsigned PW         = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  req_type          req_data,
   output cmd_kind_type     cmd_kind,
   output logic [PW-1:0]    cmd_page,
   output cfg_type          cfg
);

   localparam logic [31:0] LOW_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

   logic [CFG_W-1:0] page_total_ff, page_total_in;
   logic [CFG_W-1:0] first_page_ff, first_page_in;
   logic             reload_ff, reload_in;
   logic [CFG_W-1:0] limit;
   logic [31:0]      page_index;
   logic             aligned, in_range;

   always_comb begin
      page_total_in = page_total_ff;
      first_page_in = first_page_ff;
      reload_in     = csr_we;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_PAGE_TOTAL: page_total_in = csr_wdata;
            REG_FIRST_PAGE: first_page_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_total_ff <= PAGE_TOTAL_RESET;
         first_page_ff <= FIRST_PAGE_RESET;
         reload_ff     <= 1'b0;
      end else begin
         page_total_ff <= page_total_in;
         first_page_ff <= first_page_in;
         reload_ff     <= reload_in;
      end
   end

   // classify: bad releases are settled here and only reported by the back end
   always_comb begin
      limit      = search_limit(page_total_ff, MAX_PAGES);
      page_index = req_data.page_address >> PAGE_SHIFT;
      aligned    = (req_data.page_address & LOW_MASK) == 32'd0;
      in_range   = page_index >= 32'(first_page_ff) && page_index < 32'(limit);
      priority if (req_data.func == FUNC_ALLOC) begin
         cmd_kind = CMD_ALLOC;
      end else if (aligned && in_range) begin
         cmd_kind = CMD_RELEASE;
      end else begin
         cmd_kind = CMD_REJECT;
      end
      cmd_page = PW'(page_index);
   end

   assign cfg = '{page_total: page_total_ff, first_page: first_page_ff, reload: reload_ff};

endmodule

>>> design/ppa_back.sv
`timescale 1ns / 1ps
`include "physical_page_allocator_assert.svh"
module ppa_back import ppa_pkg::*; #(
   parameter int unsigned MAX_PAGES  = 4096,
   parameter int unsigned PAGE_SHIFT = 12,
   parameter int unsigned PW         = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          cmd_empty,
   input  cmd_kind_type  cmd_kind,
   input  logic [PW-1:0] cmd_page,
   output logic          cmd_pop,
   input  logic          rsp_full,
   output logic          rsp_push,
   output rsp_type       rsp_data,
   output logic          clearing
);

   localparam int unsigned WORDS = (MAX_PAGES + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
   localparam logic [MAP_WORD_W-1:0] ONE_BIT = {{(MAP_WORD_W-1){1'b0}}, 1'b1};

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_REL_CHECK,
      S_REPLY
   } state_type;

   // one bit per page: a page's use count is only ever zero or one
   logic [MAP_WORD_W-1:0] map_mem [WORDS];
   logic [MAP_WORD_W-1:0] rdata_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [MAP_WORD_W-1:0] mem_wdata;

   state_type        state_ff, state_in;
   logic [AW-1:0]    scan_addr_ff, scan_addr_in;
   logic             issue_ff, issue_in;
   logic             chk_ff, chk_in;
   logic [AW-1:0]    chk_addr_ff, chk_addr_in;
   logic [PW-1:0]    cmd_page_ff, cmd_page_in;
   logic [CFG_W-1:0] free_ff, free_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CFG_W-1:0]      limit, last_page, reload_value;
   logic                  range_empty;
   logic [AW-1:0]         first_word, last_word, head_word, rel_word;
   logic [MAP_BIT_W-1:0]  first_bit, last_bit, hit_bit, rel_bit;
   logic [MAP_WORD_W-1:0] lo_mask, hi_mask, free_bits, hit_onehot, rel_onehot;
   logic                  hit;
   logic [PW-1:0]         hit_page;
   logic [CFG_W:0]        new_free;

   always_comb begin
      limit        = search_limit(cfg.page_total, MAX_PAGES);
      range_empty  = limit <= cfg.first_page;
      last_page    = limit - 13'd1;
      first_word   = AW'(cfg.first_page >> MAP_BIT_W);
      last_word    = AW'(last_page >> MAP_BIT_W);
      first_bit    = cfg.first_page[MAP_BIT_W-1:0];
      last_bit     = last_page[MAP_BIT_W-1:0];
      reload_value = (cfg.first_page >= cfg.page_total) ? '0
                                                        : cfg.page_total - cfg.first_page;
      head_word    = AW'(cmd_page >> MAP_BIT_W);
      rel_word     = AW'(cmd_page_ff >> MAP_BIT_W);
      rel_bit      = cmd_page_ff[MAP_BIT_W-1:0];
      rel_onehot   = ONE_BIT << rel_bit;
      new_free     = {1'b0, free_ff} + 14'd1;

      lo_mask   = (chk_addr_ff == first_word) ? ({MAP_WORD_W{1'b1}} << first_bit)
                                              : {MAP_WORD_W{1'b1}};
      hi_mask   = (chk_addr_ff == last_word)
                ? ({MAP_WORD_W{1'b1}} >> (MAP_BIT_W'(MAP_WORD_W - 1) - last_bit))
                : {MAP_WORD_W{1'b1}};
      free_bits = ~rdata_ff & lo_mask & hi_mask;
      hit       = |free_bits;
      hit_bit   = '0;
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            hit_bit = MAP_BIT_W'(i);
         end
      end
      hit_page   = PW'({chk_addr_ff, hit_bit});
      hit_onehot = ONE_BIT << hit_bit;
   end

   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      issue_in     = issue_ff;
      chk_in       = 1'b0;
      chk_addr_in  = chk_addr_ff;
      cmd_page_in  = cmd_page_ff;
      free_in      = free_ff;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = chk_addr_ff;
      mem_wdata    = rdata_ff;
      mem_raddr    = scan_addr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_addr_ff;
            mem_wdata = '0;
            if (scan_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            mem_raddr = head_word;
            if (!cmd_empty) begin
               cmd_pop                = 1'b1;
               cmd_page_in            = cmd_page;
               rsp_in.granted_address = '0;
               rsp_in.pages_free      = free_ff;
               unique case (cmd_kind)
                  CMD_ALLOC: begin
                     if (range_empty) begin
                        rsp_in.status = STATUS_NO_MEMORY;
                        state_in      = S_REPLY;
                     end else begin
                        scan_addr_in = first_word;
                        issue_in     = 1'b1;
                        state_in     = S_SCAN;
                     end
                  end
                  CMD_RELEASE: state_in = S_REL_CHECK;
                  default: begin
                     rsp_in.status = STATUS_BAD_ADDRESS;
                     state_in      = S_REPLY;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               chk_in       = 1'b1;
               chk_addr_in  = scan_addr_ff;
               scan_addr_in = scan_addr_ff + 1'b1;
               issue_in     = scan_addr_ff != last_word;
            end
            if (chk_ff) begin
               if (hit) begin
                  state_in = S_REPLY;
                  issue_in = 1'b0;
                  chk_in   = 1'b0;
                  if (free_ff == '0) begin
                     rsp_in.status          = STATUS_COUNT_ERROR;
                     rsp_in.granted_address = '0;
                     rsp_in.pages_free      = free_ff;
                  end else begin
                     mem_we                 = 1'b1;
                     mem_waddr              = chk_addr_ff;
                     mem_wdata              = rdata_ff | hit_onehot;
                     free_in                = free_ff - 13'd1;
                     rsp_in.status          = STATUS_OK;
                     rsp_in.granted_address = 32'(hit_page) << PAGE_SHIFT;
                     rsp_in.pages_free      = free_ff - 13'd1;
                  end
               end else if (chk_addr_ff == last_word) begin
                  state_in               = S_REPLY;
                  issue_in               = 1'b0;
                  chk_in                 = 1'b0;
                  rsp_in.status          = STATUS_NO_MEMORY;
                  rsp_in.granted_address = '0;
                  rsp_in.pages_free      = free_ff;
               end
            end
         end
         S_REL_CHECK: begin
            state_in               = S_REPLY;
            rsp_in.granted_address = '0;
            rsp_in.pages_free      = free_ff;
            priority if (!rdata_ff[rel_bit]) begin
               rsp_in.status = STATUS_NOT_IN_USE;
            end else if (new_free == '0 || new_free >= {1'b0, cfg.page_total}) begin
               rsp_in.status = STATUS_COUNT_ERROR;
            end else begin
               mem_we            = 1'b1;
               mem_waddr         = rel_word;
               mem_wdata         = rdata_ff & ~rel_onehot;
               free_in           = new_free[CFG_W-1:0];
               rsp_in.status     = STATUS_OK;
               rsp_in.pages_free = new_free[CFG_W-1:0];
            end
         end
         S_REPLY: begin
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg.reload) begin
         free_in = reload_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_addr_ff <= '0;
         issue_ff     <= 1'b0;
         chk_ff       <= 1'b0;
         free_ff      <= FREE_RESET;
      end else begin
         state_ff     <= state_in;
         scan_addr_ff <= scan_addr_in;
         issue_ff     <= issue_in;
         chk_ff       <= chk_in;
         free_ff      <= free_in;
      end
      chk_addr_ff <= chk_addr_in;
      cmd_page_ff <= cmd_page_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= map_mem[mem_raddr];
   end

   assign rsp_push = state_ff == S_REPLY && !rsp_full;
   assign rsp_data = rsp_ff;
   assign clearing = state_ff == S_CLEAR;

   `PPA_ASSERT_NEXT(a_issue_stop, clock, reset,
      state_ff == S_SCAN && issue_ff && scan_addr_ff == last_word, !issue_ff)
   `PPA_ASSERT_NEXT(a_reply_idle, clock, reset, rsp_push, state_ff == S_IDLE)
   `PPA_ASSERT_NEXT(a_alloc_dec, clock, reset,
      state_ff == S_SCAN && mem_we && !cfg.reload, free_ff == $past(free_ff) - 13'd1)
   `PPA_ASSERT_IMPLY(a_grant_ok, clock, reset,
      rsp_push && rsp_ff.granted_address != '0, rsp_ff.status == STATUS_OK)

endmodule

>>> design/physical_page_allocator.sv
`timescale 1ns / 1ps
// Path from accept to result: the front end classifies a request, the command queue holds it,
// and the back end pops it; a rejected release or an allocate on an empty range goes straight
// to the reply state, a release passes through the release check, and an allocate scans the
// map words (64 pages per word, one word read per cycle from the map memory) before replying.
// The back end serves one request at a time; up to two requests queue ahead of it and two
// results wait behind it. Reset: synchronous; the page map is cleared word by word with full
// held high; registers return to page_total 4096, first page 0, free 4096.
module physical_page_allocator import ppa_pkg::*; #(
   parameter int unsigned MAX_PAGES  = 4096,
   parameter int unsigned PAGE_SHIFT = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  req_type          req_data,
   output logic             empty,
   input  logic             pop,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int unsigned PW    = $clog2(MAX_PAGES);
   localparam int unsigned KW    = $bits(cmd_kind_type);
   localparam int unsigned CMD_W = KW + PW;
   localparam int unsigned RSP_W = $bits(rsp_type);

   cmd_kind_type     front_kind, back_kind;
   logic [PW-1:0]    front_page, back_page;
   cfg_type          cfg;
   logic             cmd_full, cmd_empty, cmd_pop, cmd_push;
   logic [CMD_W-1:0] cmd_out;
   logic             rsp_full, rsp_push, clearing;
   rsp_type          back_rsp;
   logic [RSP_W-1:0] rsp_out;

   assign full      = cmd_full || clearing;
   assign cmd_push  = push && !full;
   assign back_kind = cmd_kind_type'(cmd_out[CMD_W-1 -: KW]);
   assign back_page = cmd_out[PW-1:0];
   assign rsp_data  = rsp_type'(rsp_out);

   ppa_front #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .PW         (PW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd_kind  (front_kind),
      .cmd_page  (front_page),
      .cfg       (cfg)
   );

   ppa_queue #(
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .data_in  ({front_kind, front_page}),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .data_out (cmd_out),
      .empty    (cmd_empty)
   );

   ppa_back #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .PW         (PW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_kind  (back_kind),
      .cmd_page  (back_page),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp),
      .clearing  (clearing)
   );

   ppa_queue #(
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .data_in  (back_rsp),
      .full     (rsp_full),
      .pop      (pop),
      .data_out (rsp_out),
      .empty    (empty)
   );

endmodule

>>> dv/page_alloc_checker.sv
`timescale 1ns / 1ps
module page_alloc_checker import ppa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  req_type          req_data,
   input  logic             empty,
   input  logic             pop,
   input  rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int unsigned      failures,
   output int unsigned      pending
);

   localparam int unsigned PAGE_COUNT = 4096;
   localparam int unsigned ADDR_SHIFT = 12;

   logic [7:0]       page_refs [PAGE_COUNT];
   logic [CFG_W-1:0] avail_count;
   logic [CFG_W-1:0] managed_count;
   logic [CFG_W-1:0] base_page;
   rsp_type          expected_rsps [$];
   int unsigned      fail_count = 0;

   assign failures = fail_count;

   function automatic logic [CFG_W-1:0] reload_count();
      if (base_page >= managed_count) begin
         return '0;
      end
      return managed_count - base_page;
   endfunction

   function automatic int unsigned scan_end();
      return (32'(managed_count) < PAGE_COUNT) ? 32'(managed_count) : PAGE_COUNT;
   endfunction

   // Apply one request to the page map and return the answer it earns.
   function automatic rsp_type serve_request(req_type r);
      rsp_type     res;
      int unsigned lim;
      int unsigned idx;
      int unsigned pick;
      bit          found;
      logic [7:0]  next_count;
      int unsigned next_free;
      res = '0;
      res.status = STATUS_OK;
      lim = scan_end();
      if (func_type'(r.func) == FUNC_ALLOC) begin
         found = 1'b0;
         pick = 0;
         for (idx = 32'(base_page); idx < lim && !found; idx++) begin
            if (page_refs[idx] == 8'd0) begin
               found = 1'b1;
               pick = idx;
            end
         end
         if (!found) begin
            res.status = STATUS_NO_MEMORY;
         end else if (avail_count == '0) begin
            res.status = STATUS_COUNT_ERROR;
         end else begin
            page_refs[pick] = 8'd1;
            avail_count = avail_count - 1'b1;
            res.granted_address = pick << ADDR_SHIFT;
         end
      end else begin
         idx = r.page_address >> ADDR_SHIFT;
         if (r.page_address[ADDR_SHIFT-1:0] != '0 || idx < 32'(base_page) || idx >= lim) begin
            res.status = STATUS_BAD_ADDRESS;
         end else if (page_refs[idx] == 8'd0) begin
            res.status = STATUS_NOT_IN_USE;
         end else begin
            next_count = page_refs[idx] - 8'd1;
            next_free = 32'(avail_count) + ((next_count == 8'd0) ? 1 : 0);
            if (next_free == 0 || next_free >= 32'(managed_count)) begin
               res.status = STATUS_COUNT_ERROR;
            end else begin
               page_refs[idx] = next_count;
               avail_count = CFG_W'(next_free);
            end
         end
      end
      res.pages_free = avail_count;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (page_refs[i]) page_refs[i] = 8'd0;
         managed_count = PAGE_TOTAL_RESET;
         base_page = FIRST_PAGE_RESET;
         avail_count = reload_count();
         expected_rsps.delete();
      end else begin
         if (csr_we) begin
            if (reg_index_type'(csr_index) == REG_PAGE_TOTAL) begin
               managed_count = csr_wdata;
            end else begin
               base_page = csr_wdata;
            end
            avail_count = reload_count();
         end
         if (push && !full) begin
            expected_rsps.push_back(serve_request(req_data));
         end
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response status", 32'(rsp_data.status), '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.granted_address !== want.granted_address) begin
                  report_mismatch("granted_address", rsp_data.granted_address,
                                  want.granted_address);
               end
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               end
               if (rsp_data.pages_free !== want.pages_free) begin
                  report_mismatch("pages_free", 32'(rsp_data.pages_free),
                                  32'(want.pages_free));
               end
            end
         end
      end
      pending <= expected_rsps.size();
   end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench import ppa_pkg::*;;

   localparam int unsigned PAGE_COUNT  = 4096;
   localparam int unsigned ADDR_SHIFT  = 12;
   localparam int unsigned ROUNDS      = 10;
   localparam int unsigned ROUND_ITEMS = 93;

   logic             clock;
   logic             reset     = 1'b1;
   logic             push      = 1'b0;
   logic             full;
   req_type          req_data  = '0;
   logic             empty;
   logic             pop       = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic             csr_index = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   int unsigned      failures;
   int unsigned      pending;
   logic             calm       = 1'b0;
   int unsigned      stall_left = 0;
   logic [CFG_W-1:0] cur_total  = PAGE_TOTAL_RESET;
   logic [CFG_W-1:0] cur_first  = FIRST_PAGE_RESET;
   logic [31:0]      held_pages [$];
   func_type         issued_funcs [$];

   physical_page_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   page_alloc_checker page_check (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Stall the response side in bursts.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 14) - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Track granted pages so releases can target them.
   always @(posedge clock) begin
      func_type f;
      if (!reset && pop && !empty && issued_funcs.size() != 0) begin
         f = issued_funcs.pop_front();
         if (f == FUNC_ALLOC && rsp_data.status == STATUS_OK) begin
            held_pages.push_back(rsp_data.granted_address);
         end
      end
   end

   task automatic send_request(func_type f, logic [31:0] addr);
      req_type r;
      r.func = f;
      r.page_address = addr;
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      issued_funcs.push_back(f);
   endtask

   task automatic pause_sender();
      if (!calm && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_range(logic [CFG_W-1:0] total, logic [CFG_W-1:0] first);
      drain();
      csr_we <= 1'b1;
      csr_index <= REG_PAGE_TOTAL;
      csr_wdata <= total;
      @(posedge clock);
      csr_index <= REG_FIRST_PAGE;
      csr_wdata <= first;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_total = total;
      cur_first = first;
   endtask

   function automatic bit in_range(logic [31:0] a);
      int unsigned idx;
      int unsigned lim;
      idx = a >> ADDR_SHIFT;
      lim = (32'(cur_total) < PAGE_COUNT) ? 32'(cur_total) : PAGE_COUNT;
      return idx >= 32'(cur_first) && idx < lim;
   endfunction

   // Prefer a held page inside the current range; keep it now and then for a double release.
   task automatic release_held_page();
      int unsigned k;
      int unsigned tries;
      logic [31:0] a;
      tries = 0;
      k = $urandom_range(0, held_pages.size() - 1);
      while (tries < 4 && !in_range(held_pages[k])) begin
         k = $urandom_range(0, held_pages.size() - 1);
         tries++;
      end
      a = held_pages[k];
      if ($urandom_range(0, 9) != 0) held_pages.delete(k);
      send_request(FUNC_RELEASE, a);
   endtask

   task automatic send_noise();
      logic [31:0] a;
      case ($urandom_range(0, 2))
         0: a = $urandom();
         1: a = $urandom_range(0, 4300) << ADDR_SHIFT;
         default: a = ($urandom_range(32'(cur_first), 32'(cur_first) + 64) << ADDR_SHIFT)
                      | $urandom_range(1, 4095);
      endcase
      if ($urandom_range(0, 4) == 0) begin
         send_request(FUNC_ALLOC, a);
      end else begin
         send_request(FUNC_RELEASE, a);
      end
   endtask

   task automatic pick_range();
      int unsigned f;
      int unsigned t;
      case ($urandom_range(0, 9))
         0: begin
            t = 4096;
            f = 0;
         end
         1: begin
            f = 0;
            t = $urandom_range(1, 4096);
         end
         8: begin
            t = $urandom_range(4097, 8191);
            f = $urandom_range(4000, 4095);
         end
         9: begin
            f = $urandom_range(1, 4096);
            t = $urandom_range(0, f);
         end
         default: begin
            f = $urandom_range(0, 4000);
            t = f + $urandom_range(1, 96);
         end
      endcase
      set_range(CFG_W'(t), CFG_W'(f));
   endtask

   task automatic run_round(int unsigned items);
      int unsigned n;
      int unsigned pick;
      for (n = 0; n < items; n++) begin
         pause_sender();
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_request(FUNC_ALLOC, $urandom());
         end else if (pick < 90 && held_pages.size() != 0) begin
            release_held_page();
         end else begin
            send_noise();
         end
      end
   endtask

   initial begin
      int unsigned round_no;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
      send_request(FUNC_ALLOC, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h0000_1001);
      send_request(FUNC_RELEASE, 32'hFFFF_FFFF);
      send_request(FUNC_RELEASE, 32'hFFFF_F000);
      send_request(FUNC_RELEASE, 32'h0010_0000);
      send_request(FUNC_ALLOC, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h0000_1000);
      // release that would bring the counter back to the total
      send_request(FUNC_RELEASE, 32'h0000_0000);

      set_range(13'd8, 13'd4);
      repeat (5) send_request(FUNC_ALLOC, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h0000_8000);
      send_request(FUNC_RELEASE, 32'h0000_4000);
      send_request(FUNC_ALLOC, 32'h0000_0000);

      set_range(13'd4096, 13'd4096);
      send_request(FUNC_ALLOC, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h0000_0000);
      send_request(FUNC_RELEASE, 32'h00FF_F000);

      set_range(13'd0, 13'd0);
      send_request(FUNC_ALLOC, 32'h0000_0000);

      set_range(13'd8191, 13'd0);
      send_request(FUNC_ALLOC, 32'h0000_0000);

      for (round_no = 0; round_no < ROUNDS; round_no++) begin
         if (round_no == ROUNDS - 1) calm <= 1'b1;
         pick_range();
         run_round(ROUND_ITEMS);
      end

      drain();
      repeat (80) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/ppa_pkg.sv
design/ppa_queue.sv
design/ppa_front.sv
design/ppa_back.sv
design/physical_page_allocator.sv
dv/page_alloc_checker.sv
dv/testbench.sv
